>>> rtl/ftrb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ftrb_pkg
// shared widths, request codes, frame constants and control types for the
// framed transmit ring burst feeder
// ----------------------------------------------------------------------------
package ftrb_pkg;

    localparam int RING_BYTES_DEF = 8192;
    localparam int FRAME_BYTES    = 8;

    localparam int REQ_W   = 2;
    localparam int WORD_W  = 32;
    localparam int ADDR_W  = 13;
    localparam int LEN_W   = 13;
    localparam int BYTE_W  = 8;

    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 40;

    localparam logic [REQ_W-1:0] REQ_SEND     = 2'd0;
    localparam logic [REQ_W-1:0] REQ_COMPLETE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_REFUSED  = 2'd2;
    localparam logic [REQ_W-1:0] REQ_READ     = 2'd3;

    // upper half of every frame, bytes 4..7: 00 00 80 7f
    localparam logic [31:0] FRAME_TAIL = 32'h7F80_0000;

    typedef struct packed {
        logic accept;
        logic load_out;
    } ftrb_cmd_t;

endpackage
`default_nettype wire

>>> rtl/ftrb_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ftrb_ctrl
// handshake controller: fetch stage and output register occupancy
// ----------------------------------------------------------------------------
module ftrb_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output ftrb_pkg::ftrb_cmd_t    cmd
);
    import ftrb_pkg::*;

    localparam logic ST_IDLE  = 1'b0;
    localparam logic ST_FETCH = 1'b1;

    logic state_reg, state_next;
    logic out_valid_reg, out_valid_next;
    logic can_load;

    assign can_load     = !out_valid_reg || m_tready;
    assign s_tready     = (state_reg == ST_IDLE) || can_load;
    assign cmd.accept   = s_tvalid && s_tready;
    assign cmd.load_out = (state_reg == ST_FETCH) && can_load;
    assign m_tvalid     = out_valid_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (cmd.accept) state_next = ST_FETCH;
            end
            ST_FETCH: begin
                if (cmd.load_out && !cmd.accept) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
`default_nettype wire

>>> rtl/ftrb_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ftrb_datapath
// ring pointers, 64-bit frame store, burst decision and result register
// ----------------------------------------------------------------------------
module ftrb_datapath #(
    parameter int RING_BYTES = ftrb_pkg::RING_BYTES_DEF
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire ftrb_pkg::ftrb_cmd_t          cmd,
    input  wire logic [ftrb_pkg::REQ_W-1:0]   req_type,
    input  wire logic [ftrb_pkg::WORD_W-1:0]  word_bits,
    input  wire logic [ftrb_pkg::ADDR_W-1:0]  read_addr,
    output logic                              status,
    output logic                              start_burst,
    output logic [ftrb_pkg::ADDR_W-1:0]       burst_addr,
    output logic [ftrb_pkg::LEN_W-1:0]        burst_len,
    output logic [ftrb_pkg::BYTE_W-1:0]       read_data
);
    import ftrb_pkg::*;

    localparam int WORDS = RING_BYTES / FRAME_BYTES;
    localparam int PW    = $clog2(RING_BYTES);
    localparam int AW    = $clog2(WORDS);
    localparam int XW    = (PW > ADDR_W) ? PW : ADDR_W;
    localparam logic [PW:0] RING_W    = (PW+1)'(RING_BYTES);
    localparam logic [PW:0] USED_MAX  = (PW+1)'(RING_BYTES - FRAME_BYTES - 1);
    localparam logic [PW:0] FRAME_W   = (PW+1)'(FRAME_BYTES);

    logic [63:0] mem [WORDS];

    logic [PW-1:0] wp_reg, wp_next;
    logic [PW-1:0] rp_reg, rp_next;
    logic [PW-1:0] ilen_reg, ilen_next;
    logic          inflight_reg, inflight_next;

    logic [63:0]       rd_word_reg;
    logic [2:0]        sel_reg;
    logic              pend_rd_reg;
    logic              pend_status_reg, pend_status_next;
    logic              pend_start_reg, pend_start_next;
    logic [PW-1:0]     pend_addr_reg, pend_addr_next;
    logic [PW-1:0]     pend_len_reg, pend_len_next;

    logic              status_reg;
    logic              start_reg;
    logic [ADDR_W-1:0] baddr_reg;
    logic [LEN_W-1:0]  blen_reg;
    logic [BYTE_W-1:0] rdata_reg;

    logic [PW:0]   used;
    logic          room;
    logic [PW:0]   wp_inc;
    logic [PW:0]   rp_sum;
    logic          try_go;
    logic [XW-1:0] addr_x;
    logic          addr_ok;
    logic          do_write;

    assign used   = (wp_reg >= rp_reg) ? ({1'b0, wp_reg} - {1'b0, rp_reg})
                                       : (RING_W - {1'b0, rp_reg} + {1'b0, wp_reg});
    assign room   = (used <= USED_MAX);
    assign wp_inc = {1'b0, wp_reg} + FRAME_W;
    assign rp_sum = {1'b0, rp_reg} + {1'b0, ilen_reg};
    assign addr_x = XW'(read_addr);
    assign addr_ok = ({1'b0, addr_x} < (XW+1)'(RING_BYTES));
    assign do_write = cmd.accept && (req_type == REQ_SEND) && room;

    always_comb begin
        wp_next          = wp_reg;
        rp_next          = rp_reg;
        ilen_next        = ilen_reg;
        inflight_next    = inflight_reg;
        pend_status_next = 1'b0;
        try_go           = 1'b0;
        unique case (req_type)
            REQ_SEND: begin
                if (room) begin
                    wp_next = (wp_inc >= RING_W) ? PW'(wp_inc - RING_W) : PW'(wp_inc);
                    try_go  = !inflight_reg;
                end else begin
                    pend_status_next = 1'b1;
                end
            end
            REQ_COMPLETE: begin
                rp_next       = (rp_sum >= RING_W) ? PW'(rp_sum - RING_W) : PW'(rp_sum);
                ilen_next     = '0;
                inflight_next = 1'b0;
                try_go        = 1'b1;
            end
            REQ_REFUSED: begin
                ilen_next     = '0;
                inflight_next = 1'b0;
            end
            REQ_READ: begin
            end
            default: begin
            end
        endcase

        pend_start_next = try_go && (wp_next != rp_next);
        pend_addr_next  = '0;
        pend_len_next   = '0;
        if (pend_start_next) begin
            pend_addr_next = rp_next;
            pend_len_next  = (wp_next >= rp_next) ? (wp_next - rp_next)
                                                  : PW'(RING_W - {1'b0, rp_next});
            ilen_next      = pend_len_next;
            inflight_next  = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_write) begin
            mem[AW'(wp_reg >> 3)] <= {FRAME_TAIL, word_bits};
        end
        if (cmd.accept) begin
            rd_word_reg <= mem[AW'(addr_x >> 3)];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg       <= '0;
            rp_reg       <= '0;
            ilen_reg     <= '0;
            inflight_reg <= 1'b0;
        end else if (cmd.accept) begin
            wp_reg       <= wp_next;
            rp_reg       <= rp_next;
            ilen_reg     <= ilen_next;
            inflight_reg <= inflight_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            sel_reg         <= read_addr[2:0];
            pend_rd_reg     <= (req_type == REQ_READ) && addr_ok;
            pend_status_reg <= pend_status_next;
            pend_start_reg  <= pend_start_next;
            pend_addr_reg   <= pend_addr_next;
            pend_len_reg    <= pend_len_next;
        end
        if (cmd.load_out) begin
            status_reg <= pend_status_reg;
            start_reg  <= pend_start_reg;
            baddr_reg  <= ADDR_W'(pend_addr_reg);
            blen_reg   <= LEN_W'(pend_len_reg);
            rdata_reg  <= pend_rd_reg ? rd_word_reg[{sel_reg, 3'b000} +: BYTE_W] : '0;
        end
    end

    assign status      = status_reg;
    assign start_burst = start_reg;
    assign burst_addr  = baddr_reg;
    assign burst_len   = blen_reg;
    assign read_data   = rdata_reg;

endmodule
`default_nettype wire

>>> rtl/framed_tx_ring_burst_feeder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// framed_tx_ring_burst_feeder
// byte ring of 8-byte frames with burst issue, completion and byte readback
// ----------------------------------------------------------------------------
// result path: the input transfer is registered in the fetch stage, with the
//   registered read of the 64-bit frame store, and then in the output register
// throughput: one item per cycle while m_tready stays high
// reset: pointers, in-flight mark and handshake state cleared at once; the
//   frame store is not cleared and needs no clearing pass
// ----------------------------------------------------------------------------
module framed_tx_ring_burst_feeder #(
    parameter int RING_BYTES = ftrb_pkg::RING_BYTES_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // word_bits[31:0], read_addr[44:32], zero fill
    input  wire logic [ftrb_pkg::S_TDATA_W-1:0]  s_tdata,
    // req_type[1:0]
    input  wire logic [ftrb_pkg::REQ_W-1:0]      s_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // status[0], start_burst[1], burst_addr[14:2], burst_len[27:15],
    // read_data[35:28], zero fill
    output logic [ftrb_pkg::M_TDATA_W-1:0]       m_tdata
);
    import ftrb_pkg::*;

    ftrb_cmd_t         cmd;
    logic              status;
    logic              start_burst;
    logic [ADDR_W-1:0] burst_addr;
    logic [LEN_W-1:0]  burst_len;
    logic [BYTE_W-1:0] read_data;

    ftrb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    ftrb_datapath #(
        .RING_BYTES (RING_BYTES)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .req_type    (s_tuser),
        .word_bits   (s_tdata[31:0]),
        .read_addr   (s_tdata[44:32]),
        .status      (status),
        .start_burst (start_burst),
        .burst_addr  (burst_addr),
        .burst_len   (burst_len),
        .read_data   (read_data)
    );

    assign m_tdata = {4'b0000, read_data, burst_len, burst_addr, start_burst, status};

endmodule
`default_nettype wire

>>> rtl/ftrb_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ftrb_checker
// port-level checks on the result stream of the ring burst feeder
// ----------------------------------------------------------------------------
module ftrb_checker (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    input  wire logic                            s_tready,
    input  wire logic                            m_tvalid,
    input  wire logic                            m_tready,
    input  wire logic [ftrb_pkg::M_TDATA_W-1:0]  m_tdata
);
    import ftrb_pkg::*;

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // a refused send never issues a burst and returns no read data
    a_refuse: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[0] |-> !m_tdata[1] && (m_tdata[35:28] == 8'h00))
        else $error("refused send with burst or data");

    // an issued burst always moves at least one frame
    a_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[1] |-> (m_tdata[27:15] != 13'd0) && (m_tdata[17:15] == 3'd0))
        else $error("burst length not a whole number of frames");

    // no result without an input transfer first
    a_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2) || $past(m_tvalid, 1))
        else $error("result without a preceding transfer");

    // result channel empty after reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind framed_tx_ring_burst_feeder ftrb_checker u_ftrb_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire

>>> tb/sv/framed_tx_ring_burst_feeder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// framed_tx_ring_burst_feeder_tb
// self-checking bench for the framed transmit ring. A queue of requests is
// built up front together with the result each one must give, taken from a
// shadow copy of the ring, its pointers and its in-flight mark. A directed
// opening covers idle completion and refusal, readback of frame bytes and
// burst chaining. Random traffic follows: mixed traffic, then a long stretch
// of sends with no completions that fills the ring until sends are refused,
// then mixed traffic again that drains the ring and wraps it. The sender
// offers transfers in bursts with gaps, and the receiver stalls on its own
// pattern, once for a long hold-off that backs the block up to its input.
// ----------------------------------------------------------------------------
module framed_tx_ring_burst_feeder_tb;
    import ftrb_pkg::*;

    localparam int RING       = RING_BYTES_DEF;
    localparam int CYCLE_CAP  = 400000;
    localparam int DRAIN_WAIT = 10;

    typedef struct packed {
        logic [REQ_W-1:0]  kind;
        logic [WORD_W-1:0] word;
        logic [ADDR_W-1:0] addr;
    } ring_req_t;

    typedef struct packed {
        logic              status;
        logic              start;
        logic [ADDR_W-1:0] baddr;
        logic [LEN_W-1:0]  blen;
        logic [BYTE_W-1:0] rdata;
    } ring_reply_t;

    typedef struct packed {
        ring_req_t   req;
        ring_reply_t reply;
    } pending_t;

    logic                 aclk;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [REQ_W-1:0]     s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    framed_tx_ring_burst_feeder dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // shadow ring state
    logic [7:0] ring_mem [RING];
    int         head_ptr;
    int         tail_ptr;
    int         run_len;
    bit         burst_busy;
    int         bytes_written;
    int         refused_sends;

    pending_t    pending_q [$];
    ring_reply_t reply_q [$];
    ring_reply_t offered_reply;

    int  total_reqs;
    int  taken_cnt;
    int  out_count;
    int  mismatches;
    int  cycle_cnt;
    bit  in_taken;

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic ring_reply_t try_issue(ring_reply_t res);
        int len;
        if (burst_busy || head_ptr == tail_ptr)
            return res;
        len = (head_ptr >= tail_ptr) ? head_ptr - tail_ptr : RING - tail_ptr;
        run_len    = len;
        burst_busy = 1'b1;
        res.start  = 1'b1;
        res.baddr  = tail_ptr[ADDR_W-1:0];
        res.blen   = len[LEN_W-1:0];
        return res;
    endfunction

    function automatic ring_reply_t frame_ring_step(ring_req_t rq);
        ring_reply_t res;
        logic [63:0] frame;
        int          used;
        res   = '0;
        frame = {8'h7F, 8'h80, 16'h0000, rq.word};
        case (rq.kind)
            REQ_SEND: begin
                used = (head_ptr >= tail_ptr) ? head_ptr - tail_ptr
                                              : RING - tail_ptr + head_ptr;
                if (RING - used - 1 < FRAME_BYTES) begin
                    res.status = 1'b1;
                end else begin
                    for (int b = 0; b < FRAME_BYTES; b++) begin
                        ring_mem[head_ptr] = frame[8*b +: 8];
                        head_ptr = (head_ptr + 1) % RING;
                    end
                    bytes_written = (bytes_written + FRAME_BYTES > RING) ? RING
                                    : bytes_written + FRAME_BYTES;
                    res = try_issue(res);
                end
            end
            REQ_COMPLETE: begin
                tail_ptr   = (tail_ptr + run_len) % RING;
                run_len    = 0;
                burst_busy = 1'b0;
                res = try_issue(res);
            end
            REQ_REFUSED: begin
                run_len    = 0;
                burst_busy = 1'b0;
            end
            default: begin
                res.rdata = ring_mem[rq.addr];
            end
        endcase
        return res;
    endfunction

    task automatic push_req(input logic [REQ_W-1:0] kind, input logic [WORD_W-1:0] word,
                            input logic [ADDR_W-1:0] addr);
        pending_t p;
        p.req.kind = kind;
        p.req.word = word;
        p.req.addr = addr;
        p.reply    = frame_ring_step(p.req);
        if (kind == REQ_SEND && p.reply.status)
            refused_sends++;
        pending_q.push_back(p);
        total_reqs++;
    endtask

    // reads only ever land on bytes already written, which fill from index 0 up
    function automatic logic [ADDR_W-1:0] pick_read_addr();
        int a;
        a = $urandom_range(0, bytes_written - 1);
        return a[ADDR_W-1:0];
    endfunction

    task automatic rand_req(input int p_send, input int p_done, input int p_refuse);
        int r;
        r = $urandom_range(0, 99);
        if (r < p_send)
            push_req(REQ_SEND, $urandom, ADDR_W'($urandom));
        else if (r < p_send + p_done)
            push_req(REQ_COMPLETE, $urandom, ADDR_W'($urandom));
        else if (r < p_send + p_done + p_refuse || bytes_written == 0)
            push_req(REQ_REFUSED, $urandom, ADDR_W'($urandom));
        else
            push_req(REQ_READ, $urandom, pick_read_addr());
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
        end
    endtask

    // sender: bursts of transfers with random gaps
    int burst_left = 0;
    int gap_left   = 0;

    always @(negedge aclk) begin
        pending_t p;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || in_taken) begin
            if (gap_left != 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (pending_q.size() != 0) begin
                p = pending_q.pop_front();
                offered_reply = p.reply;
                s_tdata  <= {3'b000, p.req.addr, p.req.word};
                s_tuser  <= p.req.kind;
                s_tvalid <= 1'b1;
                if (burst_left != 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 40);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver: stall pattern changes from phase to phase, one long hold-off
    int phase_left = 0;
    int stall_pct  = 0;
    int hold_left  = 0;
    bit long_hold_done = 1'b0;

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (!long_hold_done && out_count >= 400) begin
            long_hold_done = 1'b1;
            hold_left = 300;
            m_tready <= 1'b0;
        end else begin
            if (phase_left == 0) begin
                phase_left = $urandom_range(20, 200);
                case ($urandom_range(0, 4))
                    0, 1:    stall_pct = 0;
                    2:       stall_pct = 25;
                    3:       stall_pct = 50;
                    default: stall_pct = 85;
                endcase
            end else begin
                phase_left--;
            end
            m_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // monitor: checks results, records input transfers
    always @(posedge aclk) begin
        ring_reply_t want;
        cycle_cnt++;
        if (cycle_cnt > CYCLE_CAP) begin
            $display("%0t: run timed out", $time);
            $display("Verification failed");
            $finish;
        end else if (!aresetn) begin
            in_taken <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                out_count++;
                if (reply_q.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result, expected none actual %h",
                             $time, m_tdata);
                end else begin
                    want = reply_q.pop_front();
                    check_field("status",      want.status, m_tdata[0]);
                    check_field("start_burst", want.start,  m_tdata[1]);
                    check_field("burst_addr",  want.baddr,  m_tdata[14:2]);
                    check_field("burst_len",   want.blen,   m_tdata[27:15]);
                    check_field("read_data",   want.rdata,  m_tdata[35:28]);
                end
            end
            if (s_tvalid && s_tready) begin
                reply_q.push_back(offered_reply);
                taken_cnt++;
            end
            in_taken <= s_tvalid && s_tready;
        end
    end

    initial begin
        int n;
        head_ptr      = 0;
        tail_ptr      = 0;
        run_len       = 0;
        burst_busy    = 1'b0;
        bytes_written = 0;
        refused_sends = 0;
        total_reqs    = 0;
        taken_cnt     = 0;
        out_count     = 0;
        mismatches    = 0;
        cycle_cnt     = 0;
        in_taken      = 1'b0;

        // directed opening
        push_req(REQ_COMPLETE, 32'h0000_0000, 13'h1FFF);   // completion while idle
        push_req(REQ_REFUSED,  32'hFFFF_FFFF, 13'h0000);   // refusal while idle
        push_req(REQ_SEND,     32'h0000_0000, 13'h1FFF);
        push_req(REQ_SEND,     32'hFFFF_FFFF, 13'h0000);   // no burst while busy
        push_req(REQ_READ,     32'h0000_0000, 13'd0);
        push_req(REQ_READ,     32'hFFFF_FFFF, 13'd6);
        push_req(REQ_READ,     32'h0000_0000, 13'd7);
        push_req(REQ_READ,     32'h0000_0000, 13'd12);
        push_req(REQ_COMPLETE, 32'h0000_0000, 13'd0);      // chains the next burst
        push_req(REQ_REFUSED,  32'h0000_0000, 13'd0);
        push_req(REQ_SEND,     32'h1234_5678, 13'd0);      // reissue after refusal
        push_req(REQ_READ,     32'h0000_0000, 13'd16);
        push_req(REQ_READ,     32'h0000_0000, 13'd19);
        push_req(REQ_COMPLETE, 32'h0000_0000, 13'd0);      // ring drains empty
        push_req(REQ_COMPLETE, 32'h0000_0000, 13'd0);
        push_req(REQ_SEND,     32'h8000_0001, 13'd0);
        push_req(REQ_SEND,     32'h7FFF_FFFE, 13'd0);
        push_req(REQ_REFUSED,  32'h0000_0000, 13'd0);
        push_req(REQ_COMPLETE, 32'h0000_0000, 13'd0);      // idle completion restarts
        push_req(REQ_READ,     32'h0000_0000, 13'd31);

        // random: mixed, then fill until sends are refused, then mixed with wrap
        repeat (400) rand_req(55, 20, 10);
        n = 0;
        while (refused_sends < 4 && n < 1250) begin
            rand_req(90, 0, 4);
            n++;
        end
        repeat (300) rand_req(55, 25, 8);

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (taken_cnt < total_reqs || reply_q.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_WAIT) @(negedge aclk);

        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
